FILE: src/i2c_rm_pkg.sv
// Shared types and constants for the I2C register master.
// Used by i2c_register_master_top and its port checker; no dependencies.
`default_nettype none

package i2c_rm_pkg;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 8;

  localparam int DEV_ADDR_W = 7;
  localparam int BYTE_W = 8;
  localparam int BIT_INDEX_W = 4;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'h51;
  localparam logic [BYTE_W-1:0] ACK_WAIT_RESET = 8'hff;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_WAIT_LIMIT = 8'd1;

  // Bit positions of the result fields in m_tdata.
  localparam int M_SCL_BIT = 0;
  localparam int M_SDA_BIT = 1;
  localparam int M_BUSY_BIT = 2;
  localparam int M_RD_DATA_LSB = 3;
  localparam int M_RD_VALID_BIT = 11;
  localparam int M_DONE_BIT = 12;

  typedef enum logic [1:0] {
    BYTE_DEV_WR,
    BYTE_REG,
    BYTE_DATA,
    BYTE_DEV_RD
  } byte_sel_t;

endpackage

`default_nettype wire

FILE: src/i2c_register_master_top.sv
// I2C register master: one bus tick per input transaction, one result per tick.
// The result of a transaction is registered and shown in the cycle after it is accepted.
// Throughput: one transaction per cycle unless a pending result is held by m_tready low; a single state update and
// output register set the rate. Reset (rst, synchronous, active high): sequencer idle, no result pending,
// device_address 0x51 and ack_wait_limit 255.
// Depends on i2c_rm_pkg.
`default_nettype none

module i2c_register_master_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // go[0], reg_addr[8:1], wr_data[16:9], byte_count[24:17], sda_in[25], zero pad
  input  wire logic [i2c_rm_pkg::S_DATA_W-1:0]    s_tdata,
  // func[0]
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // scl_out[0], sda_out[1], busy_res[2], rd_data[10:3], rd_valid[11], done_res[12], zero pad
  output logic [i2c_rm_pkg::M_DATA_W-1:0]         m_tdata,
  // rd_last
  output logic                                    m_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [i2c_rm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2c_rm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [4:0] {
    IDLE, STA_A, STA_B, TX_L, TX_H, ACK_L, ACK_H,
    RS_A, RS_B, RS_C, RS_D, RX_L, RX_H, MA_L, MA_H,
    STO_A, STO_B, STO_C
  } state_t;

  state_t state, state_next, state_eff;
  i2c_rm_pkg::byte_sel_t byte_sel, byte_sel_next, load_sel;
  logic do_load;

  logic [i2c_rm_pkg::DEV_ADDR_W-1:0]  device_address;
  logic [i2c_rm_pkg::BYTE_W-1:0]      ack_wait_limit;
  logic [i2c_rm_pkg::BIT_INDEX_W-1:0] bit_index, bit_index_next, bit_index_inc;
  logic [i2c_rm_pkg::BYTE_W-1:0]      bytes_left, bytes_left_next;
  logic [i2c_rm_pkg::BYTE_W-1:0]      shift_reg, shift_reg_next, rx_shift;
  logic [i2c_rm_pkg::BYTE_W-1:0]      ack_wait_count, ack_wait_count_next;
  logic                               cmd_func, cmd_func_next;
  logic [i2c_rm_pkg::BYTE_W-1:0]      cmd_reg, cmd_reg_next;
  logic [i2c_rm_pkg::BYTE_W-1:0]      cmd_wr, cmd_wr_next;

  logic                          in_go, in_sda;
  logic [i2c_rm_pkg::BYTE_W-1:0] in_reg, in_wr, in_cnt;
  logic                          last_byte;

  logic scl_o, sda_o, busy_o, rdv_o, rdl_o, done_o;
  logic [i2c_rm_pkg::BYTE_W-1:0] rdd_o;

  logic accept;

  assign in_go  = s_tdata[0];
  assign in_reg = s_tdata[8:1];
  assign in_wr  = s_tdata[16:9];
  assign in_cnt = s_tdata[24:17];
  assign in_sda = s_tdata[25];

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign bit_index_inc = bit_index + 4'd1;
  assign rx_shift      = {shift_reg[6:0], in_sda};
  assign last_byte     = (bytes_left <= 8'd1);

  always_comb begin
    state_next          = state;
    byte_sel_next       = byte_sel;
    bit_index_next      = bit_index;
    bytes_left_next     = bytes_left;
    shift_reg_next      = shift_reg;
    ack_wait_count_next = ack_wait_count;
    cmd_func_next       = cmd_func;
    cmd_reg_next        = cmd_reg;
    cmd_wr_next         = cmd_wr;
    do_load             = 1'b0;
    load_sel            = i2c_rm_pkg::BYTE_DEV_WR;
    scl_o  = 1'b1;
    sda_o  = 1'b1;
    busy_o = 1'b1;
    rdd_o  = '0;
    rdv_o  = 1'b0;
    rdl_o  = 1'b0;
    done_o = 1'b0;

    state_eff = state;
    if (state == IDLE && in_go) begin
      state_eff           = STA_A;
      cmd_func_next       = s_tuser;
      cmd_reg_next        = in_reg;
      cmd_wr_next         = in_wr;
      bytes_left_next     = (in_cnt == 8'd0) ? 8'd1 : in_cnt;
      bit_index_next      = '0;
      shift_reg_next      = '0;
      ack_wait_count_next = '0;
    end

    unique case (state_eff)
      STA_A: begin
        sda_o = 1'b0;
        state_next = STA_B;
      end
      STA_B: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
        do_load = 1'b1;
        load_sel = i2c_rm_pkg::BYTE_DEV_WR;
      end
      TX_L: begin
        scl_o = 1'b0;
        sda_o = shift_reg[7];
        state_next = TX_H;
      end
      TX_H: begin
        sda_o = shift_reg[7];
        bit_index_next = bit_index_inc;
        shift_reg_next = {shift_reg[6:0], 1'b0};
        state_next = (bit_index_inc >= 4'd8) ? ACK_L : TX_L;
      end
      ACK_L: begin
        scl_o = 1'b0;
        ack_wait_count_next = '0;
        state_next = ACK_H;
      end
      ACK_H: begin
        if (!in_sda || ack_wait_count >= ack_wait_limit) begin
          ack_wait_count_next = '0;
          unique case (byte_sel)
            i2c_rm_pkg::BYTE_DEV_WR: begin
              do_load = 1'b1;
              load_sel = i2c_rm_pkg::BYTE_REG;
            end
            i2c_rm_pkg::BYTE_REG: begin
              if (cmd_func) begin
                state_next = RS_A;
              end else begin
                do_load = 1'b1;
                load_sel = i2c_rm_pkg::BYTE_DATA;
              end
            end
            i2c_rm_pkg::BYTE_DATA: state_next = STO_A;
            i2c_rm_pkg::BYTE_DEV_RD: begin
              bit_index_next = '0;
              shift_reg_next = '0;
              state_next = RX_L;
            end
          endcase
        end else begin
          ack_wait_count_next = ack_wait_count + 8'd1;
        end
      end
      RS_A: begin
        scl_o = 1'b0;
        state_next = RS_B;
      end
      RS_B: state_next = RS_C;
      RS_C: begin
        sda_o = 1'b0;
        state_next = RS_D;
      end
      RS_D: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
        do_load = 1'b1;
        load_sel = i2c_rm_pkg::BYTE_DEV_RD;
      end
      RX_L: begin
        scl_o = 1'b0;
        state_next = RX_H;
      end
      RX_H: begin
        shift_reg_next = rx_shift;
        bit_index_next = bit_index_inc;
        if (bit_index_inc >= 4'd8) begin
          rdv_o = 1'b1;
          rdd_o = rx_shift;
          rdl_o = last_byte;
          state_next = MA_L;
        end else begin
          state_next = RX_L;
        end
      end
      MA_L: begin
        scl_o = 1'b0;
        sda_o = last_byte;
        state_next = MA_H;
      end
      MA_H: begin
        sda_o = last_byte;
        if (last_byte) begin
          bytes_left_next = '0;
          state_next = STO_A;
        end else begin
          bytes_left_next = bytes_left - 8'd1;
          bit_index_next = '0;
          shift_reg_next = '0;
          state_next = RX_L;
        end
      end
      STO_A: begin
        scl_o = 1'b0;
        sda_o = 1'b0;
        state_next = STO_B;
      end
      STO_B: begin
        sda_o = 1'b0;
        state_next = STO_C;
      end
      STO_C: begin
        done_o = 1'b1;
        state_next = IDLE;
      end
      default: begin
        busy_o = 1'b0;
        state_next = IDLE;
      end
    endcase

    if (do_load) begin
      unique case (load_sel)
        i2c_rm_pkg::BYTE_DEV_WR: shift_reg_next = {device_address, 1'b0};
        i2c_rm_pkg::BYTE_REG:    shift_reg_next = cmd_reg;
        i2c_rm_pkg::BYTE_DATA:   shift_reg_next = cmd_wr;
        i2c_rm_pkg::BYTE_DEV_RD: shift_reg_next = {device_address, 1'b1};
      endcase
      bit_index_next = '0;
      byte_sel_next = load_sel;
      state_next = TX_L;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      byte_sel       <= i2c_rm_pkg::BYTE_DEV_WR;
      bit_index      <= '0;
      bytes_left     <= '0;
      shift_reg      <= '0;
      ack_wait_count <= '0;
      cmd_func       <= 1'b0;
      m_tvalid       <= 1'b0;
      device_address <= i2c_rm_pkg::DEV_ADDR_RESET;
      ack_wait_limit <= i2c_rm_pkg::ACK_WAIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == i2c_rm_pkg::REG_DEVICE_ADDRESS) begin
          device_address <= cfg_data[i2c_rm_pkg::DEV_ADDR_W-1:0];
        end else if (cfg_index == i2c_rm_pkg::REG_ACK_WAIT_LIMIT) begin
          ack_wait_limit <= cfg_data;
        end
      end
      if (accept) begin
        state          <= state_next;
        byte_sel       <= byte_sel_next;
        bit_index      <= bit_index_next;
        bytes_left     <= bytes_left_next;
        shift_reg      <= shift_reg_next;
        ack_wait_count <= ack_wait_count_next;
        cmd_func       <= cmd_func_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg <= cmd_reg_next;
      cmd_wr  <= cmd_wr_next;
      m_tdata <= {3'b000, done_o, rdv_o, rdd_o, busy_o, sda_o, scl_o};
      m_tlast <= rdl_o;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2c_rm_checker.sv
// Port-level checker for the I2C register master, bound to i2c_register_master_top.
// Depends on i2c_rm_pkg.
`default_nettype none

module i2c_rm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [i2c_rm_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic                            m_tlast
);

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled result transaction changed.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[i2c_rm_pkg::M_RD_VALID_BIT])
    else $error("Last flag without a read byte.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[i2c_rm_pkg::M_DONE_BIT] || !m_tdata[i2c_rm_pkg::M_SCL_BIT])
    |-> m_tdata[i2c_rm_pkg::M_BUSY_BIT])
    else $error("Bus activity reported while not busy.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[i2c_rm_pkg::M_BUSY_BIT]
    |-> m_tdata[i2c_rm_pkg::M_SCL_BIT] && m_tdata[i2c_rm_pkg::M_SDA_BIT]
        && !m_tdata[i2c_rm_pkg::M_RD_VALID_BIT])
    else $error("Idle bus not released.");

  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled with no result pending.");

endmodule

bind i2c_register_master_top i2c_rm_checker u_i2c_rm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
